[rtl/core/assert_macros.svh]
// Assertion macros used by the line raster top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define LRPB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define LRPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);
`else
`define LRPB_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define LRPB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/core/lrpb_pkg.sv]
// Package with geometry constants, command codes and state type of the line raster unit.
`default_nettype none
package lrpb_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_ROWS     = 8;
  localparam int PAGE_SHIFT    = 3;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(STORE_BYTES);
  // error term spans roughly -255..255 for 8-bit coordinates
  localparam int ERR_W         = 11;

  localparam logic [1:0] FUNC_LINE   = 2'd0;
  localparam logic [1:0] FUNC_FILL   = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZEROS = 8'h00;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINE_RD,
    ST_LINE_WR,
    ST_FILL,
    ST_READ
  } state_t;

endpackage
`default_nettype wire

[rtl/core/line_raster_to_page_buffer_unit.sv]
// Top level: page-layout frame buffer with Bresenham line stepper, fill sweep and byte read.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+----------------------------
//  command | in_func, in_start_x/y, in_end_x/y, in_pixel_on,| start & !busy accepts item
//          | in_byte_address                               |
//  result  | out_read_byte, out_done_func                  | out_valid, one cycle, no stall
//
// A line visits each pixel in a read state and then a write state, one buffer read per pixel and one
// write per on-screen pixel through the frame memory's separate read and write ports, then the result strobe.
// A fill sweeps every buffer byte, one write a cycle over STORE_BYTES (1024) bytes, then the strobe.
// A read returns the registered memory byte (zero if out of range); an unused command answers next cycle.
// After reset a clearing pass over all STORE_BYTES (1024) bytes zeroes the buffer, busy stays high.
// The result strobe lasts one cycle and cannot be held off by the receiver.
`default_nettype none
`include "assert_macros.svh"

module line_raster_to_page_buffer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_func,
  input  wire logic [7:0] in_start_x,
  input  wire logic [7:0] in_start_y,
  input  wire logic [7:0] in_end_x,
  input  wire logic [7:0] in_end_y,
  input  wire logic       in_pixel_on,
  input  wire logic [9:0] in_byte_address,
  output logic            out_valid,
  output logic [7:0]      out_read_byte,
  output logic [1:0]      out_done_func
);

  localparam int AW = lrpb_pkg::ADDR_W;
  localparam int EW = lrpb_pkg::ERR_W;

  // frame memory
  logic [7:0]    mem [lrpb_pkg::STORE_BYTES];
  logic [7:0]    rdata_r;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_we;

  // control and datapath registers
  lrpb_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    cnt_r, cnt_nxt;
  logic [7:0]       x_r, x_nxt, y_r, y_nxt;
  logic [7:0]       ex_r, ex_nxt, ey_r, ey_nxt;
  logic [7:0]       dx_r, dx_nxt, dy_r, dy_nxt;
  logic             sx_neg_r, sx_neg_nxt, sy_neg_r, sy_neg_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic             on_r, on_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [1:0]       out_func_r, out_func_nxt;

  // combinational helpers
  logic            accept;
  logic            onscreen;
  logic            at_end;
  logic            cnt_last;
  logic [AW-1:0]   pix_idx;
  logic [7:0]      pix_mask;
  logic [7:0]      in_dx, in_dy;
  logic signed [EW-1:0] dx_s, dy_s;
  logic            step_x, step_y;
  logic            rd_in_range;

  assign accept   = start && !busy;
  assign busy     = (state_r != lrpb_pkg::ST_IDLE);
  assign onscreen = ({1'b0, x_r} < 9'(lrpb_pkg::SCREEN_WIDTH)) &&
                    ({1'b0, y_r} < 9'(lrpb_pkg::SCREEN_HEIGHT));
  assign at_end   = (x_r == ex_r) && (y_r == ey_r);
  assign cnt_last = (cnt_r == AW'(lrpb_pkg::STORE_BYTES - 1));
  assign pix_idx  = AW'(32'(x_r) + 32'(y_r >> lrpb_pkg::PAGE_SHIFT) *
                        32'(lrpb_pkg::SCREEN_WIDTH));
  assign pix_mask = 8'(9'd1 << y_r[lrpb_pkg::PAGE_SHIFT-1:0]);
  assign in_dx    = (in_end_x > in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
  assign in_dy    = (in_end_y > in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;
  assign dx_s     = signed'(EW'(dx_r));
  assign dy_s     = signed'(EW'(dy_r));
  // error rule decisions on the error before the step
  assign step_x   = (err_r > -dx_s);
  assign step_y   = (err_r < dy_s);
  assign rd_in_range = (32'(in_byte_address) < 32'(lrpb_pkg::STORE_BYTES));

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_byte_r;
  assign out_done_func = out_func_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrpb_pkg::ST_CLEAR: begin
        if (cnt_last) state_nxt = lrpb_pkg::ST_IDLE;
      end
      lrpb_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_func)
            lrpb_pkg::FUNC_LINE: state_nxt = lrpb_pkg::ST_LINE_RD;
            lrpb_pkg::FUNC_FILL: state_nxt = lrpb_pkg::ST_FILL;
            lrpb_pkg::FUNC_READ: state_nxt = lrpb_pkg::ST_READ;
            default:             state_nxt = lrpb_pkg::ST_IDLE;
          endcase
        end
      end
      lrpb_pkg::ST_LINE_RD: state_nxt = lrpb_pkg::ST_LINE_WR;
      lrpb_pkg::ST_LINE_WR: begin
        state_nxt = at_end ? lrpb_pkg::ST_IDLE : lrpb_pkg::ST_LINE_RD;
      end
      lrpb_pkg::ST_FILL: begin
        if (cnt_last) state_nxt = lrpb_pkg::ST_IDLE;
      end
      lrpb_pkg::ST_READ: state_nxt = lrpb_pkg::ST_IDLE;
      default:           state_nxt = lrpb_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory controls and result
  always_comb begin
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sx_neg_nxt    = sx_neg_r;
    sy_neg_nxt    = sy_neg_r;
    err_nxt       = err_r;
    on_nxt        = on_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_func_nxt  = out_func_r;
    mem_raddr     = pix_idx;
    mem_waddr     = cnt_r;
    mem_wdata     = lrpb_pkg::BYTE_ZEROS;
    mem_we        = 1'b0;
    case (state_r)
      lrpb_pkg::ST_CLEAR: begin
        // after reset, zero the buffer one byte a cycle
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
      end
      lrpb_pkg::ST_IDLE: begin
        // latch the command and issue the read address for a byte read
        mem_raddr = AW'(in_byte_address);
        if (accept) begin
          x_nxt        = in_start_x;
          y_nxt        = in_start_y;
          ex_nxt       = in_end_x;
          ey_nxt       = in_end_y;
          dx_nxt       = in_dx;
          dy_nxt       = in_dy;
          sx_neg_nxt   = !(in_start_x < in_end_x);
          sy_neg_nxt   = !(in_start_y < in_end_y);
          err_nxt      = (in_dx > in_dy) ? signed'(EW'(in_dx >> 1))
                                         : -signed'(EW'(in_dy >> 1));
          on_nxt       = in_pixel_on;
          rd_ok_nxt    = rd_in_range;
          cnt_nxt      = '0;
          out_func_nxt = in_func;
          if (in_func == lrpb_pkg::FUNC_UNUSED) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = lrpb_pkg::BYTE_ZEROS;
          end
        end
      end
      lrpb_pkg::ST_LINE_RD: begin
        // fetch the byte holding the current pixel
        mem_raddr = pix_idx;
      end
      lrpb_pkg::ST_LINE_WR: begin
        // merge the pixel bit, then advance the error stepper
        mem_waddr = pix_idx;
        mem_wdata = on_r ? (rdata_r | pix_mask) : (rdata_r & ~pix_mask);
        mem_we    = onscreen;
        if (at_end) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = lrpb_pkg::BYTE_ZEROS;
        end else begin
          err_nxt = err_r - (step_x ? dy_s : EW'(0)) + (step_y ? dx_s : EW'(0));
          if (step_x) x_nxt = sx_neg_r ? x_r - 8'd1 : x_r + 8'd1;
          if (step_y) y_nxt = sy_neg_r ? y_r - 8'd1 : y_r + 8'd1;
        end
      end
      lrpb_pkg::ST_FILL: begin
        // write one byte a cycle with the fill value
        mem_we    = 1'b1;
        mem_wdata = on_r ? lrpb_pkg::BYTE_ONES : lrpb_pkg::BYTE_ZEROS;
        cnt_nxt   = cnt_r + AW'(1);
        if (cnt_last) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = lrpb_pkg::BYTE_ZEROS;
        end
      end
      lrpb_pkg::ST_READ: begin
        // return the registered byte, zero when out of range
        out_valid_nxt = 1'b1;
        out_byte_nxt  = rd_ok_r ? rdata_r : lrpb_pkg::BYTE_ZEROS;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrpb_pkg::ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sx_neg_r   <= sx_neg_nxt;
    sy_neg_r   <= sy_neg_nxt;
    err_r      <= err_nxt;
    on_r       <= on_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_byte_r <= out_byte_nxt;
    out_func_r <= out_func_nxt;
  end

  // checks
  `LRPB_ASSERT_SAME(a_strobe_idle, clk, rst_n, out_valid_r, state_r == lrpb_pkg::ST_IDLE, "result strobe outside idle")
  `LRPB_ASSERT_NEXT(a_accept_moves, clk, rst_n, accept, busy || out_valid_r, "accepted item neither busy nor answered")
  `LRPB_ASSERT_SAME(a_zero_byte, clk, rst_n, out_valid_r && (out_func_r != lrpb_pkg::FUNC_READ), out_byte_r == lrpb_pkg::BYTE_ZEROS, "nonzero byte for non-read command")
  `LRPB_ASSERT_NEXT(a_line_end, clk, rst_n, (state_r == lrpb_pkg::ST_LINE_WR) && at_end, out_valid_r && (out_func_r == lrpb_pkg::FUNC_LINE), "line end without result")

endmodule
`default_nettype wire
